// ----- rtl/rlht_pkg.sv -----
// Shared types, widths, constants and angle helpers for the heading turn limiter.
`default_nettype none

package rlht_pkg;

    // Fixed field widths of the request and response.
    localparam int ANG_W    = 20;
    localparam int POS_W    = 20;
    localparam int STEP_W   = 14;
    localparam int OUT_W    = 17;

    // Position difference, one bit wider than a position.
    localparam int D_W      = POS_W + 1;
    // Working width of the turn limiter, room for sums of two angles.
    localparam int DIFF_W   = ANG_W + 2;

    // Vectoring CORDIC datapath: magnitudes are scaled by 2^32.
    localparam int CORDIC_SHIFT = 32;
    localparam int XY_W         = 56;
    localparam int Z_W          = 33;
    localparam int TABLE_LEN    = 24;

    // Angle wrap by reciprocal multiplication.
    localparam int AU_W     = ANG_W + 1;
    localparam int RECIP_SH = 40;
    localparam int RECIP_W  = 28;
    localparam int PROD_W   = AU_W + RECIP_W;
    localparam int Q_W      = PROD_W - RECIP_SH;

    // Parameter defaults.
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // Pi in Q.32 and pi/2 in Q.30.
    localparam longint PI_Q32      = 64'sd13493037705;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Pi rounded to nearest with the given number of fraction bits.
    function automatic longint pi_q(input int frac);
        return (PI_Q32 + (longint'(1) << (31 - frac))) >>> (32 - frac);
    endfunction

    // atan(2^-i) in Q.30; past the tenth stage the angle equals the shift.
    function automatic longint atan_q30(input int idx);
        longint v;
        case (idx)
            0:       v = 64'sd843314857;
            1:       v = 64'sd497837829;
            2:       v = 64'sd263043837;
            3:       v = 64'sd133525159;
            4:       v = 64'sd67021687;
            5:       v = 64'sd33543516;
            6:       v = 64'sd16775851;
            7:       v = 64'sd8388437;
            8:       v = 64'sd4194283;
            9:       v = 64'sd2097149;
            default: v = longint'(1) << (30 - idx);
        endcase
        return v;
    endfunction

    // Everything that rides along the CORDIC next to the vector.
    typedef struct packed {
        logic                     op;
        logic signed [ANG_W-1:0]  cur;
        logic signed [ANG_W-1:0]  tgt;
        logic [STEP_W-1:0]        step;
        logic                     dx_neg;
        logic                     dy_neg;
        logic                     both_zero;
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/rlht_req_if.sv -----
// Request channel of the heading turn limiter: handshake plus one heading update.
`default_nettype none

interface rlht_req_if import rlht_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [ANG_W-1:0]  cur_angle;
    logic [STEP_W-1:0]        turn_step;
    logic signed [ANG_W-1:0]  target_heading;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;

    modport source (
        output valid, op, cur_angle, turn_step, target_heading,
               pos_x, pos_y, goal_x, goal_y,
        input  ready
    );

    modport sink (
        input  valid, op, cur_angle, turn_step, target_heading,
               pos_x, pos_y, goal_x, goal_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rlht_rsp_if.sv -----
// Response channel of the heading turn limiter: handshake plus the new heading.
`default_nettype none

interface rlht_rsp_if import rlht_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  new_angle;

    modport source (
        output valid, new_angle,
        input  ready
    );

    modport sink (
        input  valid, new_angle,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/rlht_wrap.sv -----
// Two-stage angle wrap to (-pi, pi] using a reciprocal multiply and one correction.
`default_nettype none

module rlht_wrap import rlht_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic signed [ANG_W-1:0] o_angle
);

    localparam longint PI_L     = pi_q(ANGLE_FRAC_BITS);
    localparam longint TWO_PI_L = 2 * PI_L;
    // Smallest multiple of two pi that lifts every input to a nonnegative value.
    localparam longint OFF_L    =
        TWO_PI_L * (((longint'(1) << (ANG_W - 1)) + TWO_PI_L - 1) / TWO_PI_L);
    localparam longint RECIP_L  = (longint'(1) << RECIP_SH) / TWO_PI_L;

    localparam logic [AU_W-1:0]    OFF_V        = AU_W'(OFF_L);
    localparam logic [AU_W-1:0]    PI_V         = AU_W'(PI_L);
    localparam logic [AU_W-1:0]    TWO_PI_V     = AU_W'(TWO_PI_L);
    localparam logic [AU_W-1:0]    PI_PLUS_V    = AU_W'(PI_L + TWO_PI_L);
    localparam logic [AU_W-1:0]    FOUR_PI_V    = AU_W'(2 * TWO_PI_L);
    localparam logic [RECIP_W-1:0] RECIP_V      = RECIP_W'(RECIP_L);

    logic [AU_W-1:0]   n_au, r_au;
    logic [Q_W-1:0]    n_q, r_q;
    logic [AU_W-1:0]   w_rem;
    logic signed [ANG_W-1:0] n_angle, r_angle;

    // Stage one: offset and quotient estimate.
    always_comb begin
        n_au = AU_W'(i_angle) + OFF_V;
        n_q  = Q_W'((PROD_W'(n_au) * PROD_W'(RECIP_V)) >> RECIP_SH);
    end

    // Stage two: remainder in [0, 4 pi), folded into (-pi, pi].
    always_comb begin
        w_rem = r_au - AU_W'(AU_W'(r_q) * TWO_PI_V);
        if (w_rem <= PI_V) begin
            n_angle = ANG_W'(w_rem);
        end else if (w_rem <= PI_PLUS_V) begin
            n_angle = ANG_W'(w_rem - TWO_PI_V);
        end else begin
            n_angle = ANG_W'(w_rem - FOUR_PI_V);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_au    <= n_au;
            r_q     <= n_q;
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ----- rtl/rlht_cordic.sv -----
// Vectoring CORDIC pipeline, one micro-rotation per register stage.
`default_nettype none

module rlht_cordic import rlht_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  t_side                  i_side,
    output logic                   o_valid,
    output logic signed [Z_W-1:0]  o_z,
    output t_side                  o_side
);

    // The last stage only needs y for its direction, so x stops one stage earlier.
    logic signed [XY_W-1:0] r_x [CORDIC_STAGES-2];
    logic signed [XY_W-1:0] r_y [CORDIC_STAGES-1];
    logic signed [Z_W-1:0]  r_z [CORDIC_STAGES];
    t_side                  r_side [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] r_vld;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        localparam logic signed [Z_W-1:0] ATAN_V = Z_W'(atan_q30(g));

        logic signed [XY_W-1:0] w_yin;
        logic signed [Z_W-1:0]  w_zin, n_z;
        t_side                  w_sin;
        logic                   w_up;

        if (g == 0) begin : g_first
            assign w_yin = i_y;
            assign w_zin = '0;
            assign w_sin = i_side;
        end else begin : g_next
            assign w_yin = r_y[g-1];
            assign w_zin = r_z[g-1];
            assign w_sin = r_side[g-1];
        end

        // Rotate clockwise while y is still nonnegative.
        assign w_up = !w_yin[XY_W-1];
        assign n_z  = w_up ? w_zin + ATAN_V : w_zin - ATAN_V;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[g]    <= n_z;
                r_side[g] <= w_sin;
            end
        end

        if (g < CORDIC_STAGES - 1) begin : g_xy
            logic signed [XY_W-1:0] w_xin, n_y;

            if (g == 0) begin : g_xfirst
                assign w_xin = i_x;
            end else begin : g_xnext
                assign w_xin = r_x[g-1];
            end

            assign n_y = w_up ? w_yin - (w_xin >>> g) : w_yin + (w_xin >>> g);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_y[g] <= n_y;
                end
            end

            if (g < CORDIC_STAGES - 2) begin : g_x
                logic signed [XY_W-1:0] n_x;

                assign n_x = w_up ? w_xin + (w_yin >>> g) : w_xin - (w_yin >>> g);

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[g] <= n_x;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CORDIC_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[CORDIC_STAGES-1];
    assign o_z     = r_z[CORDIC_STAGES-1];
    assign o_side  = r_side[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/rlht_limit.sv -----
// Target angle recovery from the CORDIC phase, then the rate-limited turn.
`default_nettype none

module rlht_limit import rlht_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [Z_W-1:0]   i_z,
    input  t_side                   i_side,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_new_angle
);

    localparam logic signed [Z_W-1:0]    HALF_V = Z_W'(HALF_PI_Q30);
    localparam logic signed [Z_W-1:0]    RND_V  = Z_W'(longint'(1) << (29 - ANGLE_FRAC_BITS));
    localparam int                       RND_SH = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0]  PI_V   = ANG_W'(pi_q(ANGLE_FRAC_BITS));
    localparam logic signed [DIFF_W-1:0] TWO_PI_D = DIFF_W'(2 * pi_q(ANGLE_FRAC_BITS));

    // Stage P: clamp, round and place the phase in its quadrant; a given target or a zero vector bypasses it.
    logic signed [Z_W-1:0]   w_zc, w_zr;
    logic signed [ANG_W-1:0] w_a, w_ax, w_ay, n_t;
    logic signed [ANG_W-1:0] r_t, r_b;
    logic [STEP_W-1:0]       r_s;
    logic                    r_p_vld;

    always_comb begin
        if (i_z < 0) begin
            w_zc = '0;
        end else if (i_z > HALF_V) begin
            w_zc = HALF_V;
        end else begin
            w_zc = i_z;
        end
        w_zr = (w_zc + RND_V) >>> RND_SH;
        w_a  = ANG_W'(w_zr);
        w_ax = i_side.dx_neg ? PI_V - w_a : w_a;
        w_ay = i_side.dy_neg ? -w_ax : w_ax;
        if (!i_side.op) begin
            n_t = i_side.tgt;
        end else if (i_side.both_zero) begin
            n_t = '0;
        end else begin
            n_t = w_ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
            r_b <= i_side.cur;
            r_s <= i_side.step;
        end
    end

    // Stage L: step along the shorter arc, or snap when within one step.
    logic signed [DIFF_W-1:0] w_t, w_b, w_s, w_d, w_ad, w_right, w_left, w_spin, w_res;
    logic                     w_same;
    logic [OUT_W-1:0]         n_out, r_out;
    logic                     r_o_vld;

    always_comb begin
        w_t     = DIFF_W'(r_t);
        w_b     = DIFF_W'(r_b);
        w_s     = signed'(DIFF_W'(r_s));
        w_d     = w_t - w_b;
        w_ad    = (w_d < 0) ? -w_d : w_d;
        w_same  = (w_t >= 0 && w_b >= 0) || (w_t <= 0 && w_b <= 0);
        w_right = ((w_t < 0) ? -w_t : w_t) + ((w_b < 0) ? -w_b : w_b);
        w_left  = TWO_PI_D - w_right;
        if (w_left < 0) begin
            w_left = -w_left;
        end
        w_spin  = (w_b > 0) ? w_s : -w_s;
        if (w_same) begin
            if (w_ad <= w_s) begin
                w_res = w_t;
            end else if (w_b < w_t) begin
                w_res = w_b + w_s;
            end else begin
                w_res = w_b - w_s;
            end
        end else begin
            if (w_right <= w_s || w_left <= w_s) begin
                w_res = w_t;
            end else if (w_right < w_left) begin
                w_res = w_b - w_spin;
            end else begin
                w_res = w_b + w_spin;
            end
        end
        n_out = w_res[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
            r_o_vld <= r_p_vld;
        end
    end

    assign o_valid     = r_o_vld;
    assign o_new_angle = signed'(r_out);

    // A recovered or given target always lies in the closed range [-pi, pi].
    a_tgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> (r_t >= -PI_V && r_t <= PI_V))
        else $error("target heading outside [-pi, pi]");

    // A result snapped on the same-sign branch is taken into the output register as computed.
    a_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_p_vld && w_same && w_ad <= w_s) |=> (r_out == $past(n_out)))
        else $error("snapped heading not registered");

endmodule

`default_nettype wire

// ----- rtl/rate_limited_heading_turn.sv -----
// Top level of the rate-limited heading turn: wrap, CORDIC atan2 and turn limiter.
// From request to response a request passes the position difference and fold stages, which
// also wrap both headings, one register stage per CORDIC rotation, then
// target recovery and the turn limiter. One request is taken every cycle while the response is not stalled; the rate is
// set by the CORDIC pipeline, one rotation stage per register. The synchronous active
// low reset clears only the valid bits; the data registers are not reset.
`default_nettype none

module rate_limited_heading_turn import rlht_pkg::*; #(
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlht_req_if.sink   i_req,
    rlht_rsp_if.source o_rsp
);

    localparam logic signed [ANG_W-1:0] PI_V = ANG_W'(pi_q(ANGLE_FRAC_BITS));
    localparam int XY_PAD = XY_W - D_W - CORDIC_SHIFT;

    // The whole pipeline moves as one: it advances whenever the output
    // register is empty or its request is being taken downstream. A stall
    // therefore freezes every stage and nothing is dropped or repeated.
    logic w_en;
    logic w_out_vld;
    logic signed [OUT_W-1:0] w_new_angle;

    assign w_en        = !w_out_vld || o_rsp.ready;
    // No request is taken while reset is held, since the valid bits are cleared then.
    assign i_req.ready = w_en && i_rst_n;

    // Stage 1: position difference. The two headings start their wrap in
    // parallel inside the wrap units.
    logic                    r1_vld, r1_op;
    logic [STEP_W-1:0]       r1_step;
    logic signed [D_W-1:0]   r1_dx, r1_dy, n1_dx, n1_dy;

    assign n1_dx = D_W'(i_req.goal_x) - D_W'(i_req.pos_x);
    assign n1_dy = D_W'(i_req.goal_y) - D_W'(i_req.pos_y);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op   <= i_req.op;
            r1_step <= i_req.turn_step;
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
        end
    end

    // Both headings are wrapped to (-pi, pi]. The wrapped target is used
    // only by requests that give the target heading directly.
    logic signed [ANG_W-1:0] w_cur_wrap, w_tgt_wrap;

    rlht_wrap #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_wrap_cur (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_req.cur_angle),
        .o_angle (w_cur_wrap)
    );

    rlht_wrap #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_wrap_tgt (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_req.target_heading),
        .o_angle (w_tgt_wrap)
    );

    // Stage 2: fold the difference vector into the first quadrant and scale
    // it for the CORDIC. The signs and the zero vector case travel along so
    // the quadrant can be restored at the end.
    logic                    r2_vld, r2_op, r2_dx_neg, r2_dy_neg, r2_zero;
    logic [STEP_W-1:0]       r2_step;
    logic signed [XY_W-1:0]  r2_x, r2_y;
    logic [D_W-1:0]          w_adx, w_ady;

    assign w_adx = r1_dx[D_W-1] ? D_W'(-r1_dx) : D_W'(r1_dx);
    assign w_ady = r1_dy[D_W-1] ? D_W'(-r1_dy) : D_W'(r1_dy);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_op     <= r1_op;
            r2_step   <= r1_step;
            r2_x      <= signed'({{XY_PAD{1'b0}}, w_adx, {CORDIC_SHIFT{1'b0}}});
            r2_y      <= signed'({{XY_PAD{1'b0}}, w_ady, {CORDIC_SHIFT{1'b0}}});
            r2_dx_neg <= r1_dx[D_W-1];
            r2_dy_neg <= r1_dy[D_W-1];
            r2_zero   <= (r1_dx == '0) && (r1_dy == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_req.valid;
            r2_vld <= r1_vld;
        end
    end

    t_side w_side_in, w_side_out;
    logic  w_cordic_vld;
    logic signed [Z_W-1:0] w_z;

    assign w_side_in = '{
        op:        r2_op,
        cur:       w_cur_wrap,
        tgt:       w_tgt_wrap,
        step:      r2_step,
        dx_neg:    r2_dx_neg,
        dy_neg:    r2_dy_neg,
        both_zero: r2_zero
    };

    // Stages 3 to CORDIC_STAGES + 2: vectoring CORDIC, giving the phase
    // of the folded vector in Q.30.
    rlht_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_vld),
        .i_x     (r2_x),
        .i_y     (r2_y),
        .i_side  (w_side_in),
        .o_valid (w_cordic_vld),
        .o_z     (w_z),
        .o_side  (w_side_out)
    );

    // Last two stages: restore the target heading, then limit the turn.
    // The second of them is the output register.
    rlht_limit #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_limit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_cordic_vld),
        .i_z         (w_z),
        .i_side      (w_side_out),
        .o_valid     (w_out_vld),
        .o_new_angle (w_new_angle)
    );

    assign o_rsp.valid     = w_out_vld;
    assign o_rsp.new_angle = w_new_angle;

    // Coming out of reset the pipeline holds no response.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !w_out_vld)
        else $error("response valid right after reset");

    // A held response blocks new requests.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_vld && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while the response is stalled");

    // The wrapped current heading lies in (-pi, pi].
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |-> (w_cur_wrap > -PI_V && w_cur_wrap <= PI_V))
        else $error("wrapped heading outside (-pi, pi]");

endmodule

`default_nettype wire
